/* src/jss_pkg.sv */
// Package for the Jacobi stencil sweep unit: value widths, register
// indexes, reset constants and the pipeline tag type. No dependencies.
`default_nettype none

package jss_pkg;

  localparam int VAL_W      = 24;
  localparam int SUM_W      = VAL_W + 2;
  localparam int GRID_W     = 8;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int GRID_MIN   = 3;
  localparam int GRID_RESET = 100;

  // Reset threshold is 0.01 in Q8.16, truncated.
  localparam logic [VAL_W-1:0] THR_RESET = VAL_W'((1 << FRAC_BITS) / 100);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);

  typedef struct packed {
    logic emit;
    logic last;
    logic clr;
  } jss_tag_t;

endpackage

`default_nettype wire

/* src/jacobi_stencil_sweep_unit.sv */
// Top level of the Jacobi stencil sweep unit: line buffer memories,
// stencil pipeline and output register. Depends on jss_pkg.
//
// Usage: the host streams the old grid in raster order on the input
// channel (in_valid_i, in_stall_o, cell_value_i). For every interior cell
// one request leaves on the output channel (out_valid_o, out_stall_i) with
// the new value, the change, the running maximum change and, on the last
// interior cell, sweep_done_o and converged_o. Boundary cells give nothing.
// Configuration goes through cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i while the block is idle; cfg_ready_o is always high.
// Throughput is one input per cycle unless the receiver stalls a result:
// each of the two line buffer memories takes one read and one write per
// cycle. An accepted input passes the memory read, neighbor sum, change and
// maximum and output register stages on its way to the output.
// Reset clears counters, the running maximum and all valid flags; the line
// buffer contents stay undefined until the first rows of a sweep fill them.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o rises in the same cycle; no result is lost or repeated.
`default_nettype none

module jacobi_stencil_sweep_unit
  import jss_pkg::*;
#(
  parameter int MAX_GRID = 128
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [VAL_W-1:0]      cell_value_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [VAL_W-1:0]      new_value_o,
  output      logic [VAL_W-1:0]      change_o,
  output      logic [VAL_W-1:0]      max_change_o,
  output      logic                  sweep_done_o,
  output      logic                  converged_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW    = $clog2(MAX_GRID);
  localparam int CMP_W = (AW + 1 > GRID_W) ? AW + 1 : GRID_W;
  localparam int GRID_RESET_EFF = (GRID_RESET > MAX_GRID) ? MAX_GRID : GRID_RESET;
  localparam logic [AW-1:0] LAST_RESET = AW'(GRID_RESET_EFF - 1);

  logic [AW-1:0]    grid_last_q;
  logic [VAL_W-1:0] thr_q;
  logic [CMP_W-1:0] gsz;
  logic [CMP_W-1:0] geff;

  logic [AW-1:0] row_q, row_d, col_q, col_d;
  logic [AW-1:0] cur_row, cur_col;
  logic          restart, pend_q, pend_d;
  jss_tag_t      in_tag;

  logic adv, in_fire, s1_fire;

  logic [VAL_W-1:0] mem_a [MAX_GRID];
  logic [VAL_W-1:0] mem_b [MAX_GRID];
  logic [VAL_W-1:0] rd_a_q, rd_b_q;

  logic             s1_valid_q;
  jss_tag_t         s1_tag_q;
  logic [AW-1:0]    s1_col_q;
  logic [VAL_W-1:0] s1_val_q;
  logic [VAL_W-1:0] a1_q, a2_q, b1_q, vp_q;
  logic [SUM_W-1:0] sum;

  logic             s2_valid_q;
  jss_tag_t         s2_tag_q;
  logic [VAL_W-1:0] s2_nv_q, s2_center_q;

  logic             s3_valid_q;
  jss_tag_t         s3_tag_q;
  logic [VAL_W-1:0] s3_nv_q, s3_ch_q;

  logic [VAL_W-1:0] max_q, base, new_max;
  logic             out_valid_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  assign gsz = CMP_W'(cfg_data_i[GRID_W-1:0]);

  always_comb begin
    geff = gsz;
    if (gsz < CMP_W'(GRID_MIN)) begin
      geff = CMP_W'(GRID_MIN);
    end else if (gsz > CMP_W'(MAX_GRID)) begin
      geff = CMP_W'(MAX_GRID);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_last_q <= LAST_RESET;
      thr_q       <= THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GRID_SIZE: grid_last_q <= AW'(geff - CMP_W'(1));
        REG_THRESHOLD: thr_q <= cfg_data_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the pipeline moves as one unless a result waits.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign in_fire    = in_valid_i && adv;
  assign s1_fire    = s1_valid_q && adv;

  // Position tracking in raster order.
  always_comb begin
    restart = (row_q > grid_last_q) || (col_q > grid_last_q);
    cur_row = restart ? '0 : row_q;
    cur_col = restart ? '0 : col_q;
    in_tag.emit = (cur_row >= AW'(2)) && (cur_col >= AW'(2));
    in_tag.last = (cur_row == grid_last_q) && (cur_col == grid_last_q);
    in_tag.clr  = pend_q;
    if (cur_col == grid_last_q) begin
      col_d = '0;
      row_d = in_tag.last ? '0 : cur_row + AW'(1);
    end else begin
      col_d = cur_col + AW'(1);
      row_d = cur_row;
    end
    pend_d = pend_q;
    if (restart) begin
      pend_d = 1'b1;
    end else if (in_tag.emit) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      pend_q <= 1'b0;
    end else if (in_fire) begin
      row_q  <= row_d;
      col_q  <= col_d;
      pend_q <= pend_d;
    end
  end

  // Line buffers: mem_a holds the row above the input, mem_b the one above that.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_a_q         <= mem_a[cur_col];
      mem_a[cur_col] <= cell_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mem_b[s1_col_q] <= rd_a_q;
    end
    if (in_fire) begin
      rd_b_q <= mem_b[cur_col];
    end
  end

  // Stage 1: neighbor sum from the read data and short delay lines.
  assign sum = (SUM_W'(b1_q) + SUM_W'(vp_q)) + (SUM_W'(a2_q) + SUM_W'(rd_a_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q && s1_tag_q.emit;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_tag_q <= in_tag;
      s1_col_q <= cur_col;
      s1_val_q <= cell_value_i;
    end
    if (s1_fire) begin
      a1_q        <= rd_a_q;
      a2_q        <= a1_q;
      b1_q        <= rd_b_q;
      vp_q        <= s1_val_q;
      s2_tag_q    <= s1_tag_q;
      s2_nv_q     <= sum[SUM_W-1:2];
      s2_center_q <= a1_q;
    end
    if (adv) begin
      s3_tag_q <= s2_tag_q;
      s3_nv_q  <= s2_nv_q;
      s3_ch_q  <= (s2_center_q > s2_nv_q) ? s2_center_q - s2_nv_q
                                          : s2_nv_q - s2_center_q;
    end
  end

  // Running maximum and output register.
  assign base    = s3_tag_q.clr ? '0 : max_q;
  assign new_max = (s3_ch_q > base) ? s3_ch_q : base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s3_valid_q;
      if (s3_valid_q) begin
        max_q <= s3_tag_q.last ? '0 : new_max;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_valid_q) begin
      new_value_o  <= s3_nv_q;
      change_o     <= s3_ch_q;
      max_change_o <= new_max;
      sweep_done_o <= s3_tag_q.last;
      converged_o  <= s3_tag_q.last && (base < thr_q) && (s3_ch_q < thr_q);
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_bank_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && in_fire) |-> (s1_col_q != cur_col))
    else $error("line buffer read and write hit the same column");

  a_max_covers_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (max_change_o >= change_o))
    else $error("running maximum below the current change");

  a_converged_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && converged_o) |-> sweep_done_o)
    else $error("converged flag outside the last interior value");

  a_max_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s3_valid_q && s3_tag_q.last) |=> (max_q == '0))
    else $error("running maximum not cleared after the sweep");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

endmodule

`default_nettype wire
